[sv/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the shortest paths engine
// Defaults for parameters, item codes, controller states and the distance
// value that marks a vertex as not reached.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int DIST_BITS = 30;
  localparam logic [DIST_BITS-1:0] UNREACHED = 30'd1000000000;

  // register indexes of the configuration port
  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_RELAX,
    ST_RELAX_END,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_t;

endpackage

[sv/ssp_ram.sv]
// ----------------------------------------------------------------------------
// ssp_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/single_source_shortest_paths.sv]
// ----------------------------------------------------------------------------
// single_source_shortest_paths: Dijkstra over an adjacency matrix in RAM
// Edge items write one matrix word; clear items sweep the matrix
// at one word a cycle; run items compute distances and stream them out.
// ----------------------------------------------------------------------------
// Run item: up to n rounds of search (per round n distance reads, n matrix
//   reads and the control states SCAN_END, DECIDE, RELAX_END), then each
//   result is read, loaded and held until it is transferred.
// Throughput: one item at a time; the next item is taken once the last
//   result of a run has been transferred.
// Reset: synchronous; the clearing pass that follows takes no items.
module single_source_shortest_paths #(
  parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = ssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [5:0]  edge_from,
  input  logic [5:0]  edge_to,
  input  logic [15:0] edge_weight,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  vertex_index,
  output logic [29:0] distance,
  output logic        reachable,
  output logic        last_result
);

  // Widths: vertex index, vertex count, matrix address, relaxation sum.
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int AD  = MAX_VERTICES * MAX_VERTICES;
  localparam int AW  = $clog2(AD);
  localparam int DB  = ssp_pkg::DIST_BITS;
  localparam int SW  = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;
  localparam int ENW = WEIGHT_BITS + 1;

  ssp_pkg::state_t state, state_next;

  // configuration registers
  logic [6:0]  vertex_count;
  logic [5:0]  source_vertex;

  // run control
  logic [CW-1:0] n_used;
  logic [CW-1:0] j;
  logic [CW-1:0] round;
  logic [AW-1:0] clr_addr;
  logic [VW-1:0] pick;
  logic [DB-1:0] best;
  logic          found;

  // per-vertex flags: visited marks and "distance written this run"
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] dist_set;

  // read pipeline: which vertex the RAM data of this cycle belongs to
  logic          s_valid;
  logic          r_valid;
  logic [VW-1:0] p_idx;

  // RAM ports
  logic           adj_we;
  logic [AW-1:0]  adj_waddr;
  logic [ENW-1:0] adj_wdata;
  logic [AW-1:0]  adj_raddr;
  logic [ENW-1:0] adj_rdata;
  logic           dist_we;
  logic [VW-1:0]  dist_waddr;
  logic [DB-1:0]  dist_wdata;
  logic [VW-1:0]  dist_raddr;
  logic [DB-1:0]  dist_rdata;

  // derived signals
  logic          in_xfer;
  logic          out_xfer;
  logic          edge_in_range;
  logic          src_in_range;
  logic [VW-1:0] src_idx;
  logic          j_last;
  logic [DB-1:0] cur_dist;
  logic [SW-1:0] relax_sum;
  logic          improve;
  logic          better;
  logic [CW-1:0] n_clamped;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  assign edge_in_range = (int'(edge_from) < MAX_VERTICES) && (int'(edge_to) < MAX_VERTICES);
  assign src_in_range  = int'(source_vertex) < MAX_VERTICES;
  assign src_idx       = VW'(source_vertex);
  assign j_last        = (j == n_used - CW'(1));

  // Clamp the vertex count to 1..MAX_VERTICES.
  always_comb begin
    if (vertex_count == 7'd0) begin
      n_clamped = CW'(1);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_clamped = CW'(MAX_VERTICES);
    end else begin
      n_clamped = CW'(vertex_count);
    end
  end

  // Distance of the vertex in the read pipeline; unwritten reads as unreached.
  assign cur_dist  = dist_set[p_idx] ? dist_rdata : ssp_pkg::UNREACHED;
  assign relax_sum = SW'(best) + SW'(adj_rdata[WEIGHT_BITS-1:0]);
  // Relaxation: edge present, head not visited, strictly shorter.
  assign improve   = r_valid && !visited[p_idx] && adj_rdata[WEIGHT_BITS]
                     && (relax_sum < SW'(cur_dist));
  // Search: least written distance among unvisited, lowest index wins ties.
  assign better    = s_valid && !visited[p_idx] && dist_set[p_idx] && (dist_rdata < best);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ssp_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(AD - 1)) state_next = ssp_pkg::ST_IDLE;
      end
      ssp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (op == ssp_pkg::OP_RUN) begin
            state_next = ssp_pkg::ST_INIT;
          end else if (op == ssp_pkg::OP_CLEAR) begin
            state_next = ssp_pkg::ST_CLEAR;
          end
        end
      end
      ssp_pkg::ST_INIT:     state_next = ssp_pkg::ST_SCAN;
      ssp_pkg::ST_SCAN: begin
        if (j_last) state_next = ssp_pkg::ST_SCAN_END;
      end
      ssp_pkg::ST_SCAN_END: state_next = ssp_pkg::ST_DECIDE;
      ssp_pkg::ST_DECIDE: begin
        state_next = found ? ssp_pkg::ST_RELAX : ssp_pkg::ST_OUT_RD;
      end
      ssp_pkg::ST_RELAX: begin
        if (j_last) state_next = ssp_pkg::ST_RELAX_END;
      end
      ssp_pkg::ST_RELAX_END: begin
        state_next = (round == n_used - CW'(1)) ? ssp_pkg::ST_OUT_RD : ssp_pkg::ST_SCAN;
      end
      ssp_pkg::ST_OUT_RD:   state_next = ssp_pkg::ST_OUT_LD;
      ssp_pkg::ST_OUT_LD:   state_next = ssp_pkg::ST_OUT_HOLD;
      ssp_pkg::ST_OUT_HOLD: begin
        if (out_ready) state_next = j_last ? ssp_pkg::ST_IDLE : ssp_pkg::ST_OUT_RD;
      end
      default:              state_next = ssp_pkg::ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and RAM controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready   = (state == ssp_pkg::ST_IDLE);
    out_valid  = (state == ssp_pkg::ST_OUT_HOLD);

    // matrix: clearing pass, or an edge write taken in idle
    adj_we     = 1'b0;
    adj_waddr  = clr_addr;
    adj_wdata  = '0;
    if (state == ssp_pkg::ST_CLEAR) begin
      adj_we = 1'b1;
    end else if (in_xfer && (op == ssp_pkg::OP_EDGE) && edge_in_range) begin
      adj_we    = 1'b1;
      adj_waddr = AW'(int'(edge_from) * MAX_VERTICES + int'(edge_to));
      adj_wdata = {1'b1, WEIGHT_BITS'(edge_weight)};
    end
    // row of the picked vertex, column j
    adj_raddr  = AW'(int'(pick) * MAX_VERTICES + int'(j));

    // distances: source at run start, otherwise relaxation write-back
    dist_raddr = VW'(j);
    dist_we    = 1'b0;
    dist_waddr = p_idx;
    dist_wdata = DB'(relax_sum);
    if (state == ssp_pkg::ST_INIT) begin
      dist_we    = src_in_range;
      dist_waddr = src_idx;
      dist_wdata = '0;
    end else if (improve) begin
      dist_we    = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ssp_pkg::ST_CLEAR;
      vertex_count  <= 7'd64;
      source_vertex <= 6'd0;
      clr_addr      <= '0;
      s_valid       <= 1'b0;
      r_valid       <= 1'b0;
      visited       <= '0;
      dist_set      <= '0;
      j             <= '0;
      round         <= '0;
      found         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        if (cfg_index == ssp_pkg::CFG_VERTEX_COUNT) begin
          vertex_count <= cfg_data;
        end else begin
          source_vertex <= cfg_data[5:0];
        end
      end

      // advance the clearing pass; rewind it when a clear item arrives
      if (state == ssp_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end else if (in_xfer && (op == ssp_pkg::OP_CLEAR)) begin
        clr_addr <= '0;
      end

      // a run starts with no visited marks and no written distances
      if (in_xfer && (op == ssp_pkg::OP_RUN)) begin
        visited  <= '0;
        dist_set <= '0;
        n_used   <= n_clamped;
      end
      if ((state == ssp_pkg::ST_INIT) && src_in_range) begin
        dist_set[src_idx] <= 1'b1;
      end
      if (improve) begin
        dist_set[p_idx] <= 1'b1;
      end
      if ((state == ssp_pkg::ST_DECIDE) && found) begin
        visited[pick] <= 1'b1;
      end

      // column / vertex counter
      case (state)
        ssp_pkg::ST_SCAN, ssp_pkg::ST_RELAX: j <= j_last ? '0 : j + CW'(1);
        ssp_pkg::ST_OUT_HOLD: begin
          if (out_ready) j <= j + CW'(1);
        end
        ssp_pkg::ST_IDLE: j <= '0;
        default: ;
      endcase

      if (state == ssp_pkg::ST_INIT) begin
        round <= '0;
      end else if (state == ssp_pkg::ST_RELAX_END) begin
        round <= round + CW'(1);
      end

      // start each search afresh
      if ((state == ssp_pkg::ST_INIT) || (state == ssp_pkg::ST_RELAX_END)) begin
        found <= 1'b0;
        best  <= ssp_pkg::UNREACHED;
      end else if (better) begin
        found <= 1'b1;
        best  <= dist_rdata;
        pick  <= p_idx;
      end

      s_valid <= (state == ssp_pkg::ST_SCAN);
      r_valid <= (state == ssp_pkg::ST_RELAX);
    end

    // payload: tag the read in flight, load the result register
    p_idx <= VW'(j);
    if (state == ssp_pkg::ST_OUT_LD) begin
      vertex_index <= 6'(p_idx);
      distance     <= cur_dist;
      reachable    <= (cur_dist < ssp_pkg::UNREACHED);
      last_result  <= j_last;
    end
  end

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  ssp_ram #(
    .WIDTH (ENW),
    .DEPTH (AD)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  ssp_ram #(
    .WIDTH (DB),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

endmodule

[sv/ssp_checker.sv]
// ----------------------------------------------------------------------------
// ssp_checker: port-level checks for the shortest paths engine
// Watches the top level's ports and reports violations.
// ----------------------------------------------------------------------------
module ssp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  vertex_index,
  input logic [29:0] distance,
  input logic        reachable,
  input logic        last_result
);

  // items are not taken while a result is on offer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance)
      && $stable(vertex_index) && $stable(last_result))
    else $error("result changed before transfer");

  a_reach_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reachable == (distance < 30'd1000000000)))
    else $error("reachable flag disagrees with distance");

  a_unreached_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> distance == 30'd1000000000)
    else $error("unreached vertex with wrong distance");

  // reset starts the clearing pass: nothing taken, nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("activity right after reset");

endmodule

bind single_source_shortest_paths ssp_checker u_ssp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .vertex_index (vertex_index),
  .distance     (distance),
  .reachable    (reachable),
  .last_result  (last_result)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the shortest paths engine
// Drives edge, clear and run items through the valid/ready input, predicts
// every distance with a behavioural Dijkstra kept in the bench, and checks
// each transfer on the result side in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;   // ignored by the block
  localparam int CYCLE_LIMIT = 2000000;
  localparam int QUIET_CYCLES = 4300;        // covers a full matrix clear

  typedef struct packed {
    logic [5:0]  vertex;
    logic [29:0] dist_val;
    logic        reach;
    logic        last;
  } dist_report_t;

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [6:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] op;
  logic [5:0] edge_from, edge_to;
  logic [15:0] edge_weight;
  logic out_valid, out_ready;
  logic [5:0] vertex_index;
  logic [29:0] distance;
  logic reachable, last_result;

  single_source_shortest_paths dut (.*);

  // shadow of the graph and the registers
  bit          edge_present [64][64];
  logic [15:0] edge_cost    [64][64];
  logic [6:0]  count_reg;
  logic [5:0]  source_reg;

  dist_report_t expected_dists[$];
  int mismatches;
  int cycles;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL single_source_shortest_paths");
      $finish;
    end
  end

  // receiver: hold off for a counted stretch, otherwise stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // check each result transfer; sample mid-cycle so nothing races the edge
  always @(negedge clk) begin
    dist_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_dists.size() == 0) begin
        note_mismatch($sformatf("unexpected result vertex %0d dist %0d",
                                vertex_index, distance));
      end else begin
        want = expected_dists.pop_front();
        if (want.vertex !== vertex_index || want.dist_val !== distance ||
            want.reach !== reachable || want.last !== last_result)
          note_mismatch($sformatf(
            "exp v%0d d%0d r%0d l%0d got v%0d d%0d r%0d l%0d",
            want.vertex, want.dist_val, want.reach, want.last,
            vertex_index, distance, reachable, last_result));
      end
    end
  end

  // Dijkstra over the shadow matrix; queue one report per vertex in use
  task automatic predict_distances();
    int n, pick;
    logic [29:0] dist_of [64];
    bit seen [64];
    logic [29:0] best;
    logic [31:0] sum;
    bit found;
    dist_report_t rep;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    for (int i = 0; i < 64; i++) begin
      dist_of[i] = ssp_pkg::UNREACHED;
      seen[i] = 1'b0;
    end
    dist_of[source_reg] = '0;
    for (int r = 0; r < n; r++) begin
      found = 1'b0;
      best = ssp_pkg::UNREACHED;
      pick = 0;
      for (int j = 0; j < n; j++) begin
        if (!seen[j] && dist_of[j] < best) begin
          best = dist_of[j];
          pick = j;
          found = 1'b1;
        end
      end
      if (!found) break;
      seen[pick] = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (!seen[j] && edge_present[pick][j]) begin
          sum = {2'b00, best} + {16'h0, edge_cost[pick][j]};
          if (sum < {2'b00, dist_of[j]}) dist_of[j] = sum[29:0];
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      rep.vertex = i[5:0];
      rep.dist_val = dist_of[i];
      rep.reach = (dist_of[i] < ssp_pkg::UNREACHED);
      rep.last = (i == n - 1);
      expected_dists.push_back(rep);
    end
  endtask

  // offer one item, hold it until the transfer, then update the shadow
  task automatic send_item(input logic [1:0] code, input logic [5:0] from,
                           input logic [5:0] to, input logic [15:0] w);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    op <= code;
    edge_from <= from;
    edge_to <= to;
    edge_weight <= w;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    case (code)
      ssp_pkg::OP_EDGE: begin
        edge_present[from][to] = 1'b1;
        edge_cost[from][to] = w;
      end
      ssp_pkg::OP_CLEAR: begin
        for (int a = 0; a < 64; a++)
          for (int b = 0; b < 64; b++) edge_present[a][b] = 1'b0;
      end
      ssp_pkg::OP_RUN: predict_distances();
      default: ;
    endcase
  endtask

  // drop the offer, wait for every result, then let a clear sweep finish
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_dists.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back; only called while idle
  task automatic set_regs(input logic [6:0] cnt, input logic [6:0] src);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= ssp_pkg::CFG_VERTEX_COUNT;
    cfg_data <= cnt;
    @(posedge clk);
    count_reg = cnt;
    cfg_index <= ssp_pkg::CFG_SOURCE_VERTEX;
    cfg_data <= src;
    @(posedge clk);
    source_reg = src[5:0];
    cfg_we <= 1'b0;
  endtask

  task automatic send_run();
    send_item(ssp_pkg::OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    // empty graph at reset settings: only the source is reached
    send_run();
    send_item(ssp_pkg::OP_EDGE, 6'd63, 6'd63, 16'hffff);
    send_item(ssp_pkg::OP_EDGE, 6'd0, 6'd63, 16'h0000);
    send_item(ssp_pkg::OP_EDGE, 6'd0, 6'd1, 16'hffff);
    send_item(ssp_pkg::OP_EDGE, 6'd1, 6'd63, 16'h0001);
    send_item(ssp_pkg::OP_EDGE, 6'd1, 6'd2, 16'h0000);
    send_run();
    // overwrite an entry, then drop an ignored item
    send_item(ssp_pkg::OP_EDGE, 6'd0, 6'd63, 16'h0005);
    send_item(OP_UNUSED, 6'd63, 6'd0, 16'hffff);
    send_run();
    send_item(ssp_pkg::OP_CLEAR, 6'd0, 6'd0, 16'h0);
    send_run();
    drain();
    // count of zero clamps to one
    set_regs(7'd0, 7'd0);
    send_run();
    drain();
    // count above the matrix clamps to the maximum, source at the top
    set_regs(7'd127, 7'd63);
    send_item(ssp_pkg::OP_EDGE, 6'd63, 6'd0, 16'h0007);
    send_item(ssp_pkg::OP_EDGE, 6'd0, 6'd5, 16'h0003);
    send_item(ssp_pkg::OP_EDGE, 6'd63, 6'd5, 16'h000a);
    send_run();
    drain();
    // source past n: none reached; src 66 acts as 2; edges past n unused
    set_regs(7'd4, 7'd10);
    send_item(ssp_pkg::OP_EDGE, 6'd10, 6'd1, 16'h0001);
    send_run();
    drain();
    set_regs(7'd4, 7'd64 + 7'd2);
    send_item(ssp_pkg::OP_EDGE, 6'd2, 6'd3, 16'h0002);
    send_item(ssp_pkg::OP_EDGE, 6'd2, 6'd40, 16'h0002);
    send_run();
    drain();
  endtask

  // well-formed blocks: registers, maybe clear, edges, run; some noise
  task automatic test_random(input int items);
    int sent, n, k;
    logic [6:0] cnt, src;
    sent = 0;
    while (sent < items) begin
      drain();
      if ($urandom_range(99) < 85) cnt = 7'($urandom_range(1, 8));
      else if ($urandom_range(1)) cnt = 7'($urandom_range(0, 127));
      else cnt = 7'd64;
      n = (cnt == 0) ? 1 : (cnt > 64 ? 64 : cnt);
      if ($urandom_range(9) < 8)
        src = 7'($urandom_range(0, n - 1)) | {1'($urandom_range(1)), 6'd0};
      else src = 7'($urandom_range(0, 127));
      set_regs(cnt, src);
      if ($urandom_range(2) == 0) begin
        send_item(ssp_pkg::OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
        sent++;
      end
      k = $urandom_range(n, 3 * n);
      if (k > 12) k = 12;
      for (int e = 0; e < k; e++) begin
        if ($urandom_range(7) == 0)
          send_item(($urandom_range(3) == ssp_pkg::OP_CLEAR) ? OP_UNUSED
                      : 2'($urandom_range(3)),
                    6'($urandom), 6'($urandom), 16'($urandom));
        else
          send_item(ssp_pkg::OP_EDGE, 6'($urandom_range(0, n - 1)),
                    6'($urandom_range(0, n - 1)),
                    $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 3)));
        sent++;
      end
      send_run();
      sent++;
    end
    drain();
  endtask

  // receiver holds off while items keep coming, so the input backs up
  task automatic test_backpressure();
    set_regs(7'd6, 7'd1);
    hold_cycles = 2000;
    send_item(ssp_pkg::OP_EDGE, 6'd1, 6'd4, 16'h0009);
    send_item(ssp_pkg::OP_EDGE, 6'd4, 6'd5, 16'h0002);
    send_run();
    send_item(ssp_pkg::OP_EDGE, 6'd1, 6'd5, 16'h0003);
    send_run();
    send_item(ssp_pkg::OP_EDGE, 6'd5, 6'd0, 16'h0001);
    send_run();
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= ssp_pkg::CFG_VERTEX_COUNT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= ssp_pkg::OP_EDGE;
    edge_from <= '0;
    edge_to <= '0;
    edge_weight <= '0;
    cycles = 0;
    mismatches = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    count_reg = 7'd64;
    source_reg = 6'd0;
    for (int a = 0; a < 64; a++)
      for (int b = 0; b < 64; b++) begin
        edge_present[a][b] = 1'b0;
        edge_cost[a][b] = '0;
      end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(25);
    send_idle_pct = 53;
    test_random(25);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    test_random(25);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    test_random(25);
    test_backpressure();

    while (expected_dists.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS single_source_shortest_paths");
    end else begin
      $display("FAIL single_source_shortest_paths");
    end
    $finish;
  end
endmodule
